// ===== rtl/core/crx_pkg.sv =====
// crx_pkg: shared types and constants for the CSI-2 style RAW10 packet receiver.
// No dependencies; imported by the result channel interface and the receiver core.
`timescale 1ns / 1ps
package crx_pkg;

   localparam int PACKET_TYPE_W = 6;
   localparam int PIXEL_W       = 10;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   // Result queue between the byte parser and the result channel.
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_COUNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [PACKET_TYPE_W-1:0] LONG_TYPE_RESET = 6'h2B;

   // Register index decoded from csr_paddr above the byte offset.
   localparam logic [CSR_ADDR_W-3:0] REG_LONG_PACKET_TYPE = '0;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_FOOTER  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      KIND_SHORT  = 3'd0,
      KIND_LONG   = 3'd1,
      KIND_PIXELS = 3'd2,
      KIND_FOOTER = 3'd3,
      KIND_BROKEN = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic [PACKET_TYPE_W-1:0] packet_type;
      logic [1:0]               channel;
      logic [15:0]              count_or_value;
      logic [7:0]               header_check;
      logic [PIXEL_W-1:0]       pixel_0;
      logic [PIXEL_W-1:0]       pixel_1;
      logic [PIXEL_W-1:0]       pixel_2;
      logic [PIXEL_W-1:0]       pixel_3;
      logic [15:0]              footer_value;
      logic                     last_of_run;
   } rsp_type;

endpackage

// ===== rtl/core/crx_req_if.sv =====
// crx_req_if: byte stream channel (valid/ready) into the receiver.
// Depends on nothing but the handshake convention.
`timescale 1ns / 1ps
interface crx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       buffer_end;

   modport source (output valid, output stream_byte, output buffer_end, input ready);
   modport sink   (input valid, input stream_byte, input buffer_end, output ready);
endinterface

// ===== rtl/core/crx_rsp_if.sv =====
// crx_rsp_if: result channel (valid/ready) out of the receiver.
// Field widths come from crx_pkg.
`timescale 1ns / 1ps
interface crx_rsp_if
   import crx_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic [2:0]               kind;
   logic [PACKET_TYPE_W-1:0] packet_type;
   logic [1:0]               channel;
   logic [15:0]              count_or_value;
   logic [7:0]               header_check;
   logic [PIXEL_W-1:0]       pixel_0;
   logic [PIXEL_W-1:0]       pixel_1;
   logic [PIXEL_W-1:0]       pixel_2;
   logic [PIXEL_W-1:0]       pixel_3;
   logic [15:0]              footer_value;
   logic                     last_of_run;

   modport source (
      output valid, output kind, output packet_type, output channel,
      output count_or_value, output header_check, output pixel_0, output pixel_1,
      output pixel_2, output pixel_3, output footer_value, output last_of_run,
      input ready
   );
   modport sink (
      input valid, input kind, input packet_type, input channel,
      input count_or_value, input header_check, input pixel_0, input pixel_1,
      input pixel_2, input pixel_3, input footer_value, input last_of_run,
      output ready
   );
endinterface

// ===== rtl/core/csi2_style_raw10_packet_receiver.sv =====
// csi2_style_raw10_packet_receiver: top level, byte parser plus result queue.
// Depends on crx_pkg, crx_req_if and crx_rsp_if.
`timescale 1ns / 1ps
// Takes a simplified CSI-2 byte stream, one byte per req transaction, at up to one
// byte per clock. Four header bytes give data type (low 6 bits of byte 0), virtual
// channel (top 2 bits of byte 0), a little-endian word count / short value (bytes 1-2)
// and a check byte (byte 3); every header is reported when its fourth byte arrives.
// A header whose type matches long_packet_type (CSR at byte address 0, reset 0x2B)
// opens a long packet: each 5-byte payload group becomes one result with four RAW10
// pixels, trailing bytes short of a group are skipped, and the 2-byte footer is
// reported unchecked. buffer_end on a byte inside a long packet (long header, payload,
// first footer byte) adds a "broken stream" result after any other result of that
// byte; buffer_end anywhere returns the parser to header phase. Each byte is parsed
// in the cycle it is accepted and its zero, one or two results go into a 4-entry
// result queue; results leave at one per clock while the sink is ready. req.ready is
// high while the queue has room for two results, so bytes are taken every cycle as
// long as the sink keeps up; a byte yielding two results needs two pops by the sink.
// Results are written into the queue at the edge that accepts their byte.
module csi2_style_raw10_packet_receiver
   import crx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   crx_req_if.sink               req,
   crx_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ---------------------------------------------------------------- CSR
   logic [PACKET_TYPE_W-1:0] long_type_ff, long_type_in;
   logic                     csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_LONG_PACKET_TYPE);

   always_comb begin
      long_type_in = long_type_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         long_type_in = csr_pwdata[PACKET_TYPE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata = {{(CSR_DATA_W-PACKET_TYPE_W){1'b0}}, long_type_ff};
      end
   end

   // ------------------------------------------------------------ parser state
   phase_type   phase_ff, phase_in;
   logic [23:0] header_ff, header_in;        // header bytes 0..2
   logic [1:0]  header_pos_ff, header_pos_in;
   logic [15:0] payload_left_ff, payload_left_in;
   logic [31:0] group_ff, group_in;          // group bytes 0..3
   logic [2:0]  group_pos_ff, group_pos_in;
   logic [7:0]  footer_low_ff, footer_low_in;
   logic        footer_pos_ff, footer_pos_in;

   logic       accept;
   logic [7:0] in_byte;
   logic       in_end;
   logic       is_long;
   logic [15:0] payload_dec;

   assign accept      = req.valid && req.ready;
   assign in_byte     = req.stream_byte;
   assign in_end      = req.buffer_end;
   assign is_long     = (header_ff[PACKET_TYPE_W-1:0] == long_type_ff);
   assign payload_dec = payload_left_ff - 16'd1;

   // Next state of the parser for the byte being accepted.
   always_comb begin
      phase_in        = phase_ff;
      header_in       = header_ff;
      header_pos_in   = header_pos_ff;
      payload_left_in = payload_left_ff;
      group_in        = group_ff;
      group_pos_in    = group_pos_ff;
      footer_low_in   = footer_low_ff;
      footer_pos_in   = footer_pos_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               unique case (header_pos_ff)
                  2'd0: header_in[7:0]   = in_byte;
                  2'd1: header_in[15:8]  = in_byte;
                  2'd2: header_in[23:16] = in_byte;
                  default: ;
               endcase
               if (header_pos_ff != 2'd3) begin
                  header_pos_in = header_pos_ff + 2'd1;
               end else begin
                  header_pos_in = '0;
                  if (is_long) begin
                     payload_left_in = header_ff[23:8];
                     group_pos_in    = '0;
                     footer_pos_in   = 1'b0;
                     phase_in = (header_ff[23:8] != 16'd0) ? PH_PAYLOAD : PH_FOOTER;
                  end
               end
            end
            PH_PAYLOAD: begin
               unique case (group_pos_ff)
                  3'd0: group_in[7:0]   = in_byte;
                  3'd1: group_in[15:8]  = in_byte;
                  3'd2: group_in[23:16] = in_byte;
                  3'd3: group_in[31:24] = in_byte;
                  default: ;
               endcase
               group_pos_in    = (group_pos_ff < 3'd4) ? group_pos_ff + 3'd1 : 3'd0;
               payload_left_in = payload_dec;
               if (payload_dec == 16'd0) begin
                  group_pos_in  = '0;
                  footer_pos_in = 1'b0;
                  phase_in      = PH_FOOTER;
               end
            end
            default: begin
               if (!footer_pos_ff) begin
                  footer_low_in = in_byte;
                  footer_pos_in = 1'b1;
               end else begin
                  footer_pos_in = 1'b0;
                  phase_in      = PH_HEADER;
               end
            end
         endcase
         // End of buffer: back to a clean header phase.
         if (in_end) begin
            phase_in        = PH_HEADER;
            header_pos_in   = '0;
            payload_left_in = '0;
            group_pos_in    = '0;
            footer_pos_in   = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------- result build
   rsp_type    main_res, broken_res, res_a, res_b;
   logic       main_vld, broken_vld;
   logic [1:0] push_n;

   always_comb begin
      main_res                = '0;
      main_res.packet_type    = header_ff[5:0];
      main_res.channel        = header_ff[7:6];
      main_res.count_or_value = header_ff[23:8];
      broken_res              = main_res;
      broken_res.kind         = KIND_BROKEN;
      broken_res.last_of_run  = 1'b1;
      main_vld                = 1'b0;
      broken_vld              = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (header_pos_ff == 2'd3) begin
                  main_vld              = 1'b1;
                  main_res.kind         = is_long ? KIND_LONG : KIND_SHORT;
                  main_res.header_check = in_byte;
                  broken_vld            = is_long && in_end;
               end
            end
            PH_PAYLOAD: begin
               broken_vld = in_end;
               if (group_pos_ff >= 3'd4) begin
                  main_vld         = 1'b1;
                  main_res.kind    = KIND_PIXELS;
                  main_res.pixel_0 = {in_byte[1:0], group_ff[7:0]};
                  main_res.pixel_1 = {in_byte[3:2], group_ff[15:8]};
                  main_res.pixel_2 = {in_byte[5:4], group_ff[23:16]};
                  main_res.pixel_3 = {in_byte[7:6], group_ff[31:24]};
               end
            end
            default: begin
               if (!footer_pos_ff) begin
                  broken_vld = in_end;
               end else begin
                  main_vld              = 1'b1;
                  main_res.kind         = KIND_FOOTER;
                  main_res.footer_value = {in_byte, footer_low_ff};
               end
            end
         endcase
      end
      main_res.last_of_run = !broken_vld;
   end

   // Pack the valid results to the front.
   always_comb begin
      res_a  = main_vld ? main_res : broken_res;
      res_b  = broken_res;
      push_n = {1'b0, main_vld} + {1'b0, broken_vld};
   end

   // ---------------------------------------------------------- result queue
   rsp_type                entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RSP_COUNT_W-1:0] count_ff, count_in;
   logic                   pop;
   logic [RSP_PTR_W-1:0]   wr_ptr_nx;

   assign pop       = rsp.valid && rsp.ready;
   assign wr_ptr_nx = wr_ptr_ff + RSP_PTR_W'(1);
   assign req.ready = (count_ff <= RSP_COUNT_W'(RSP_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + RSP_COUNT_W'(push_n) - RSP_COUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[wr_ptr_ff] <= res_a;
      end
      if (push_n == 2'd2) begin
         entry_ff[wr_ptr_nx] <= res_b;
      end
   end

   assign rsp.valid          = (count_ff != '0);
   assign rsp.kind           = entry_ff[rd_ptr_ff].kind;
   assign rsp.packet_type    = entry_ff[rd_ptr_ff].packet_type;
   assign rsp.channel        = entry_ff[rd_ptr_ff].channel;
   assign rsp.count_or_value = entry_ff[rd_ptr_ff].count_or_value;
   assign rsp.header_check   = entry_ff[rd_ptr_ff].header_check;
   assign rsp.pixel_0        = entry_ff[rd_ptr_ff].pixel_0;
   assign rsp.pixel_1        = entry_ff[rd_ptr_ff].pixel_1;
   assign rsp.pixel_2        = entry_ff[rd_ptr_ff].pixel_2;
   assign rsp.pixel_3        = entry_ff[rd_ptr_ff].pixel_3;
   assign rsp.footer_value   = entry_ff[rd_ptr_ff].footer_value;
   assign rsp.last_of_run    = entry_ff[rd_ptr_ff].last_of_run;

   // ---------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         long_type_ff    <= LONG_TYPE_RESET;
         phase_ff        <= PH_HEADER;
         header_ff       <= '0;
         header_pos_ff   <= '0;
         payload_left_ff <= '0;
         group_ff        <= '0;
         group_pos_ff    <= '0;
         footer_low_ff   <= '0;
         footer_pos_ff   <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         long_type_ff    <= long_type_in;
         phase_ff        <= phase_in;
         header_ff       <= header_in;
         header_pos_ff   <= header_pos_in;
         payload_left_ff <= payload_left_in;
         group_ff        <= group_in;
         group_pos_ff    <= group_pos_in;
         footer_low_ff   <= footer_low_in;
         footer_pos_ff   <= footer_pos_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         count_ff        <= count_in;
      end
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for csi2_style_raw10_packet_receiver (byte stream in,
// header/pixel/footer results out). Depends on crx_pkg, crx_req_if, crx_rsp_if and the RTL.
module tb_top
   import crx_pkg::*;
;

   localparam int BYTES_PER_PHASE = 300;
   localparam int NUM_PHASES      = 5;
   localparam int DRAIN_CYCLES    = 4;     // settling margin after the last result
   localparam int MAX_PRINTED     = 40;
   localparam logic [CSR_ADDR_W-1:0] LONG_TYPE_ADDR = {REG_LONG_PACKET_TYPE, 2'b00};

   // Per-phase long packet code and idle pressure; the last phase draws its code at random.
   localparam logic [5:0] PHASE_CODES [NUM_PHASES] = '{6'h00, 6'h3F, 6'h15, 6'h2B, 6'h00};
   localparam int         PHASE_GAP   [NUM_PHASES] = '{0, 30, 60, 10, 40};
   localparam int         PHASE_STALL [NUM_PHASES] = '{0, 30, 10, 60, 40};

   // Results that can be read straight off the stream; all others come from the parser model.
   localparam rsp_type NO_RESULT  = '0;
   localparam rsp_type ZERO_SHORT = '{KIND_SHORT, 6'h00, 2'd0, 16'h0000, 8'h00,
                                      10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b1};
   localparam rsp_type ONES_SHORT = '{KIND_SHORT, 6'h3F, 2'd3, 16'hFFFF, 8'hFF,
                                      10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b1};
   localparam rsp_type LONG_SIX   = '{KIND_LONG, 6'h2B, 2'd0, 16'h0006, 8'h00,
                                      10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b1};

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       buffer_end;
      logic       typed;        // 1: the single result is given in want
      rsp_type    want;
   } stim_row_type;

   // Directed stream, run with the reset long packet code (0x2B).
   localparam int NUM_DIRECTED = 26;
   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // all-zero short header right after reset
      '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b1, ZERO_SHORT},
      // all-ones short header: type 0x3F, channel 3, value 0xFFFF
      '{8'hFF, 1'b0, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, 1'b1, ONES_SHORT},
      // long packet, six payload bytes: one full group, one byte left over
      '{8'h2B, 1'b0, 1'b0, NO_RESULT}, '{8'h06, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b1, LONG_SIX},
      '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hE4, 1'b0, 1'b0, NO_RESULT}, '{8'h77, 1'b0, 1'b0, NO_RESULT},
      // footer 0xFF00
      '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      // empty long packet on channel 3, buffer ends on the header: long + broken
      '{8'hEB, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'h5A, 1'b1, 1'b0, NO_RESULT},
      // partial header cut by buffer end: dropped silently
      '{8'h12, 1'b0, 1'b0, NO_RESULT}, '{8'h34, 1'b1, 1'b0, NO_RESULT}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   crx_req_if req_if ();
   crx_rsp_if rsp_if ();

   csi2_style_raw10_packet_receiver uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Parser model state, mirrors the receiver's architectural state.
   phase_type   parse_phase;
   logic [23:0] hdr_bytes;      // header bytes 0..2
   logic [1:0]  hdr_count;
   logic [15:0] words_left;
   logic [31:0] grp_bytes;      // low bytes of the current 5-byte group
   logic [2:0]  grp_count;
   logic [7:0]  footer_lo;
   logic        footer_half;
   logic [5:0]  long_code;

   rsp_type parsed [2];         // results of the byte just parsed
   rsp_type expected_results [$];

   // Stimulus knobs and bookkeeping.
   int gap_pct;
   int stall_pct;
   int burst_left;
   int rsp_stall_left;
   int bytes_sent;
   int results_seen;
   int error_count;

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                   results_seen, name, got, want));
   endtask

   // Any buffer end sends the parser back to header phase with counts cleared.
   function automatic void clear_positions();
      parse_phase = PH_HEADER;
      hdr_count   = '0;
      words_left  = '0;
      grp_count   = '0;
      footer_half = 1'b0;
   endfunction

   // Every result carries the fields of the last gathered header.
   function automatic rsp_type packet_result(input kind_type k);
      rsp_type r;
      r                = '0;
      r.kind           = k;
      r.packet_type    = hdr_bytes[5:0];
      r.channel        = hdr_bytes[7:6];
      r.count_or_value = hdr_bytes[23:8];
      return r;
   endfunction

   task automatic unpack_stream_byte(input logic [7:0] b, input logic e, output int n);
      rsp_type r;
      logic    broken;
      logic    is_long;
      n      = 0;
      broken = 1'b0;
      case (parse_phase)
         PH_HEADER: begin
            if (hdr_count < 2'd3) begin
               hdr_bytes[8*hdr_count +: 8] = b;
               hdr_count++;
            end else begin
               is_long        = (hdr_bytes[5:0] == long_code);
               r              = packet_result(is_long ? KIND_LONG : KIND_SHORT);
               r.header_check = b;
               parsed[n]      = r;
               n++;
               hdr_count      = '0;
               if (is_long) begin
                  words_left  = hdr_bytes[23:8];
                  grp_count   = '0;
                  footer_half = 1'b0;
                  // zero word count skips straight to the footer
                  parse_phase = (words_left != 0) ? PH_PAYLOAD : PH_FOOTER;
                  broken      = e;
               end
            end
         end
         PH_PAYLOAD: begin
            if (grp_count < 3'd4) begin
               grp_bytes[8*grp_count +: 8] = b;
               grp_count++;
            end else begin
               // fifth byte holds the two high bits of each pixel
               r         = packet_result(KIND_PIXELS);
               r.pixel_0 = {b[1:0], grp_bytes[7:0]};
               r.pixel_1 = {b[3:2], grp_bytes[15:8]};
               r.pixel_2 = {b[5:4], grp_bytes[23:16]};
               r.pixel_3 = {b[7:6], grp_bytes[31:24]};
               parsed[n] = r;
               n++;
               grp_count = '0;
            end
            words_left--;
            if (words_left == 0) begin
               // an unfinished group is dropped here
               grp_count   = '0;
               footer_half = 1'b0;
               parse_phase = PH_FOOTER;
            end
            broken = e;
         end
         default: begin
            if (!footer_half) begin
               footer_lo   = b;
               footer_half = 1'b1;
               broken      = e;
            end else begin
               r              = packet_result(KIND_FOOTER);
               r.footer_value = {b, footer_lo};
               parsed[n]      = r;
               n++;
               footer_half    = 1'b0;
               parse_phase    = PH_HEADER;
            end
         end
      endcase
      if (broken) begin
         parsed[n] = packet_result(KIND_BROKEN);
         n++;
      end
      if (e)
         clear_positions();
      if (n > 0)
         parsed[n-1].last_of_run = 1'b1;
   endtask

   // Sends one byte, with bursty gaps, and books its results once accepted.
   task automatic send_byte(input logic [7:0] b, input logic e, input logic typed,
                            input rsp_type want);
      int gap;
      int n;
      if (burst_left == 0) begin
         if ($urandom_range(1, 100) <= gap_pct) begin
            gap = $urandom_range(1, 6);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_if.valid       <= 1'b1;
      req_if.stream_byte <= b;
      req_if.buffer_end  <= e;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      unpack_stream_byte(b, e, n);
      if (typed)
         expected_results.push_back(want);
      else
         for (int i = 0; i < n; i++)
            expected_results.push_back(parsed[i]);
      bytes_sent++;
   endtask

   // Holds the stream until every booked result is back, then lets the pipe settle.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One APB transaction: setup cycle, then access cycle until pready.
   task automatic csr_access(input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= LONG_TYPE_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_long_code();
      logic [31:0] rd;
      csr_access(1'b0, '0, rd);
      if (rd[5:0] !== long_code)
         report_mismatch($sformatf("long_packet_type read 0x%0h, expected 0x%0h",
                                   rd[5:0], long_code));
   endtask

   // Upper bits get noise; only the low six bits are kept.
   task automatic set_long_code(input logic [5:0] code);
      logic [31:0] unused_rd;
      csr_access(1'b1, {26'($urandom), code}, unused_rd);
      long_code = code;
      @(posedge clock);
      check_long_code();
   endtask

   // One buffer: mostly well-formed packets, some cut short, some noise.
   task automatic send_buffer();
      logic [7:0]  bytes_q [$];
      logic [5:0]  dtype;
      logic [15:0] wc;
      logic        is_long;
      int          sel;
      int          cut;
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         repeat ($urandom_range(1, 12)) bytes_q.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(1, 4)) begin
            is_long = 1'($urandom_range(0, 1));
            if (is_long) begin
               dtype = long_code;
               wc    = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(17, 80))
                                                   : 16'($urandom_range(0, 16));
            end else begin
               // keep short packets short: never hit the long code by chance
               dtype = 6'($urandom_range(0, 63));
               if (dtype == long_code)
                  dtype++;
               wc = 16'($urandom);
            end
            bytes_q.push_back({2'($urandom_range(0, 3)), dtype});
            bytes_q.push_back(wc[7:0]);
            bytes_q.push_back(wc[15:8]);
            bytes_q.push_back(8'($urandom));
            if (is_long) begin
               repeat (wc) bytes_q.push_back(8'($urandom));
               repeat (2) bytes_q.push_back(8'($urandom));
            end
         end
      end
      cut = bytes_q.size() - 1;
      if (sel >= 10 && sel < 25)
         cut = $urandom_range(0, bytes_q.size() - 1);   // buffer ends mid-stream
      for (int i = 0; i <= cut; i++)
         send_byte(bytes_q[i], i == cut, 1'b0, NO_RESULT);
   endtask

   // Result sink: stalls in short runs at the current stall rate.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_stall_left != 0) begin
            rsp_stall_left--;
            rsp_if.ready <= 1'b0;
         end else if ($urandom_range(1, 100) <= stall_pct) begin
            rsp_stall_left = $urandom_range(0, 3);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Scoreboard: every result transaction is matched against the oldest booked one.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected",
                                      results_seen));
         end else begin
            want = expected_results.pop_front();
            check_field("kind",           16'(rsp_if.kind),
                        16'(want.kind));
            check_field("packet_type",    16'(rsp_if.packet_type),
                        16'(want.packet_type));
            check_field("channel",        16'(rsp_if.channel),
                        16'(want.channel));
            check_field("count_or_value", rsp_if.count_or_value, want.count_or_value);
            check_field("header_check",   16'(rsp_if.header_check),
                        16'(want.header_check));
            check_field("pixel_0",        16'(rsp_if.pixel_0), 16'(want.pixel_0));
            check_field("pixel_1",        16'(rsp_if.pixel_1), 16'(want.pixel_1));
            check_field("pixel_2",        16'(rsp_if.pixel_2), 16'(want.pixel_2));
            check_field("pixel_3",        16'(rsp_if.pixel_3), 16'(want.pixel_3));
            check_field("footer_value",   rsp_if.footer_value,   want.footer_value);
            check_field("last_of_run",    16'(rsp_if.last_of_run),
                        16'(want.last_of_run));
         end
         results_seen++;
      end
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #1_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [5:0] code;
      int         phase_start;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.stream_byte <= '0;
      req_if.buffer_end  <= 1'b0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      gap_pct        = 0;
      stall_pct      = 0;
      burst_left     = 0;
      rsp_stall_left = 0;
      bytes_sent     = 0;
      results_seen   = 0;
      error_count    = 0;
      hdr_bytes      = '0;
      grp_bytes      = '0;
      footer_lo      = '0;
      long_code      = LONG_TYPE_RESET;
      clear_positions();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // register must come out of reset at 0x2B
      check_long_code();

      // directed stream at full rate
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_byte(DIRECTED_ROWS[i].stream_byte, DIRECTED_ROWS[i].buffer_end,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

      // random phases; the code changes only with the pipe empty
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         code = (p == NUM_PHASES - 1) ? 6'($urandom_range(0, 63)) : PHASE_CODES[p];
         set_long_code(code);
         gap_pct     = PHASE_GAP[p];
         stall_pct   = PHASE_STALL[p];
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
            send_buffer();
            if ($urandom_range(0, 39) == 0)
               wait_drained();   // sender holds off until all results are in
         end
      end

      wait_drained();
      if (error_count == 0 && expected_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
